### rtl/lpht_pkg.sv
// Package for the linear-probe hash table: operation and mark codes,
// slot entry layout, FNV-1a constants and key masking.
// No dependencies.
package lpht_pkg;

	typedef enum logic [1:0] {
		OP_SET = 2'd0,
		OP_GET = 2'd1,
		OP_DEL = 2'd2
	} lpht_op_t;

	typedef enum logic [1:0] {
		MARK_EMPTY = 2'd0,
		MARK_LIVE  = 2'd1,
		MARK_TOMB  = 2'd2
	} lpht_mark_t;

	typedef struct packed {
		logic [1:0]  mark;
		logic [3:0]  len;
		logic [63:0] key;
		logic [63:0] value;
	} lpht_entry_t;

	localparam logic [63:0] FNV_BASIS   = 64'hcbf29ce484222325;
	// prime is 2^40 + 0x1b3
	localparam int          FNV_SHIFT   = 40;
	localparam logic [8:0]  FNV_LOW     = 9'h1b3;
	localparam int          LOAD_NUM    = 10;
	localparam int          LOAD_DEN    = 7;

	// keeps the low len bytes of a key
	function automatic logic [63:0] key_mask(input logic [3:0] len);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (4'(b) < len) begin
				m[b*8 +: 8] = 8'hff;
			end
		end
		return m;
	endfunction

endpackage

### rtl/lpht_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing.
interface lpht_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [63:0] key_bytes;
	logic [3:0]  key_length;
	logic [63:0] new_value;
	modport source (output valid, operation, key_bytes, key_length, new_value, input ready);
	modport sink (input valid, operation, key_bytes, key_length, new_value, output ready);
endinterface

interface lpht_rsp_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [63:0] read_value;
	logic [6:0]  live_entries;
	modport source (output valid, ok, read_value, live_entries, input ready);
	modport sink (input valid, ok, read_value, live_entries, output ready);
endinterface

### rtl/linear_probe_hash_table.sv
// Channel   Dir  Payload                                          Accept
// req       in   operation, key_bytes, key_length, new_value      valid && ready
// rsp       out  ok, read_value, live_entries                     valid && ready
//
// One request at a time. Hashing runs over the key bytes, then a modulo
// reduction when TABLE_DEPTH is not a power of two; each probed slot is read
// through the registered RAM read port, up to TABLE_DEPTH slots.
// After reset a clearing pass marks every slot empty, with req.ready
// low. A waiting response does not block the next request.
// Depends on lpht_pkg, lpht_if, lpht_ram, lpht_hash.
module linear_probe_hash_table #(
	parameter int TABLE_DEPTH = 64,
	parameter int KEY_BYTES   = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	lpht_req_if.sink   req,
	lpht_rsp_if.source rsp
);
	import lpht_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);
	localparam logic [CW+3:0] LIMIT = (CW+4)'(TABLE_DEPTH * LOAD_DEN);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_HASH  = 6'b000100,
		S_READ  = 6'b001000,
		S_CHECK = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t        state_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] slot_q;
	logic [AW-1:0] probe_q;
	logic [CW-1:0] count_q;
	logic [1:0]    op_q;
	logic [63:0]   key_q;
	logic [3:0]    len_q;
	logic [63:0]   val_q;
	logic          ok_q;
	logic [63:0]   rd_q;
	logic          out_v_q;
	logic          out_ok_q;
	logic [63:0]   out_rd_q;
	logic [6:0]    out_cnt_q;

	// request side: saturate length, clear bytes above it
	logic          accept;
	logic [3:0]    len_sat;
	logic [63:0]   key_m;

	logic          hash_done;
	logic [AW-1:0] home;

	lpht_entry_t   rd_ent;
	lpht_entry_t   wr_ent;
	logic          we;
	logic [AW-1:0] waddr;
	logic          match;
	logic          full;

	assign accept  = req.valid && req.ready;
	assign len_sat = (req.key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : req.key_length;
	assign key_m   = req.key_bytes & key_mask(len_sat);
	assign req.ready = (state_q == S_IDLE);

	lpht_hash #(.DEPTH(TABLE_DEPTH)) u_hash (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.key   (key_m),
		.len   (len_sat),
		.done  (hash_done),
		.home  (home)
	);

	lpht_ram #(.WIDTH($bits(lpht_entry_t)), .DEPTH(TABLE_DEPTH)) u_slots (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wr_ent),
		.raddr(slot_q),
		.rdata(rd_ent)
	);

	// load check: count*10 >= depth*7 refuses a set
	assign full  = ((CW+4)'(count_q) * (CW+4)'(LOAD_NUM)) >= LIMIT;
	assign match = (rd_ent.len == len_q) && (rd_ent.key == key_q);

	// slot write: clearing pass, insert/update on set, tombstone on delete
	always_comb begin
		we     = 1'b0;
		waddr  = slot_q;
		wr_ent = '{mark: MARK_LIVE, len: len_q, key: key_q, value: val_q};
		if (state_q == S_CLEAR) begin
			we     = 1'b1;
			waddr  = clr_q;
			wr_ent = '{mark: MARK_EMPTY, len: 4'd0, key: 64'd0, value: 64'd0};
		end else if (state_q == S_CHECK) begin
			if (op_q == OP_SET) begin
				we = (rd_ent.mark != MARK_LIVE) || match;
			end else if (op_q == OP_DEL) begin
				we     = (rd_ent.mark == MARK_LIVE) && match;
				wr_ent = '{mark: MARK_TOMB, len: rd_ent.len, key: rd_ent.key, value: 64'd0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			count_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			// a new response loads as the old one leaves
			if (state_q == S_DONE && (!out_v_q || rsp.ready)) begin
				out_v_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (hash_done) begin
						case (op_q)
							OP_SET:  state_q <= full ? S_DONE : S_READ;
							OP_GET,
							OP_DEL:  state_q <= S_READ;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_READ: state_q <= S_CHECK;
				S_CHECK: begin
					if (op_q == OP_SET) begin
						if (rd_ent.mark != MARK_LIVE) begin
							count_q <= count_q + CW'(1);
							state_q <= S_DONE;
						end else if (match || probe_q == LAST) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_READ;
						end
					end else begin
						if (rd_ent.mark == MARK_LIVE && match) begin
							if (op_q == OP_DEL && count_q != '0) begin
								count_q <= count_q - CW'(1);
							end
							state_q <= S_DONE;
						end else if (rd_ent.mark == MARK_EMPTY || probe_q == LAST) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_DONE: begin
					// hold here only while the previous response is unread
					if (!out_v_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q  <= req.operation;
				key_q <= key_m;
				len_q <= len_sat;
				val_q <= req.new_value;
				ok_q  <= 1'b0;
				rd_q  <= 64'd0;
			end
			S_HASH: begin
				slot_q  <= home;
				probe_q <= '0;
			end
			S_CHECK: begin
				slot_q  <= (slot_q == LAST) ? '0 : slot_q + AW'(1);
				probe_q <= probe_q + AW'(1);
				if (op_q == OP_SET) begin
					ok_q <= (rd_ent.mark != MARK_LIVE) || match;
				end else begin
					ok_q <= (rd_ent.mark == MARK_LIVE) && match;
					if (op_q == OP_GET && rd_ent.mark == MARK_LIVE && match) begin
						rd_q <= rd_ent.value;
					end
				end
			end
			S_DONE: begin
				if (!out_v_q || rsp.ready) begin
					out_ok_q  <= ok_q;
					out_rd_q  <= rd_q;
					out_cnt_q <= 7'(count_q);
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid        = out_v_q;
	assign rsp.ok           = out_ok_q;
	assign rsp.read_value   = out_rd_q;
	assign rsp.live_entries = out_cnt_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("live count above table depth");

	a_hash_in_hash: assert property (@(posedge clk) disable iff (!arst_n)
		hash_done |-> state_q == S_HASH)
		else $error("hash finished outside hash phase");

	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == S_CLEAR || state_q == S_CHECK))
		else $error("slot write outside clear or probe");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |=> $stable(count_q))
		else $error("live count moved while idle");
`endif
endmodule

### rtl/lpht_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### rtl/lpht_hash.sv
// Iterative FNV-1a hasher (one byte a cycle), then, if the depth is not a power
// of two, byte-serial reduction modulo it by reciprocal multiplication. Uses lpht_pkg.
module lpht_hash #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [63:0]              key,
	input  logic [3:0]               len,
	output logic                     done,
	output logic [$clog2(DEPTH)-1:0] home
);
	import lpht_pkg::*;

	localparam int  AW   = $clog2(DEPTH);
	localparam int  XW   = AW + 8;
	localparam bit  POW2 = (DEPTH & (DEPTH - 1)) == 0;
	localparam logic [AW:0] DEP = (AW+1)'(DEPTH);
	// floor(2^XW / DEPTH); quotient estimate is low by at most one
	localparam logic [8:0]  RECIP = 9'((2**XW) / DEPTH);

	typedef enum logic [2:0] {
		H_IDLE = 3'b001,
		H_BYTE = 3'b010,
		H_MOD  = 3'b100
	} hstate_t;

	hstate_t        state_q;
	logic [63:0]    h_q;
	logic [63:0]    key_q;
	logic [3:0]     left_q;
	logic [3:0]     mcnt_q;
	logic [AW-1:0]  rem_q;
	logic [XW-1:0]  x_q;
	logic [7:0]     qa_q;
	logic [AW-1:0]  home_q;
	logic           done_q;

	logic [63:0]    hx;
	logic [63:0]    h_next;
	logic [XW-1:0]  x_cur;
	logic [XW+8:0]  prod;
	logic [XW-1:0]  qd;
	logic [XW-1:0]  diff;
	logic [AW:0]    rem_w;
	logic [AW-1:0]  rem_next;

	always_comb begin
		hx     = h_q ^ {56'd0, key_q[7:0]};
		h_next = (hx << FNV_SHIFT) + 64'(hx * 64'(FNV_LOW));
		// odd count: estimate quotient of {rem, top byte}
		x_cur  = {rem_q, h_q[63:56]};
		prod   = (XW+9)'(x_cur) * (XW+9)'(RECIP);
		// even count: remainder from the estimate, one fix-up subtract
		qd     = XW'(qa_q) * XW'(DEPTH);
		diff   = x_q - qd;
		rem_w  = diff[AW:0];
		if (rem_w >= DEP) begin
			rem_next = AW'(rem_w - DEP);
		end else begin
			rem_next = rem_w[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				H_IDLE: begin
					if (start) begin
						state_q <= H_BYTE;
					end
				end
				H_BYTE: begin
					if (left_q == 4'd0) begin
						if (POW2) begin
							done_q  <= 1'b1;
							state_q <= H_IDLE;
						end else begin
							state_q <= H_MOD;
						end
					end
				end
				H_MOD: begin
					if (mcnt_q == 4'd0) begin
						done_q  <= 1'b1;
						state_q <= H_IDLE;
					end
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			H_IDLE: begin
				h_q    <= FNV_BASIS;
				key_q  <= key;
				left_q <= len;
			end
			H_BYTE: begin
				if (left_q != 4'd0) begin
					h_q    <= h_next;
					key_q  <= key_q >> 8;
					left_q <= left_q - 4'd1;
				end else begin
					home_q <= h_q[AW-1:0];
					rem_q  <= '0;
					mcnt_q <= 4'd15;
				end
			end
			H_MOD: begin
				mcnt_q <= mcnt_q - 4'd1;
				if (mcnt_q[0]) begin
					x_q  <= x_cur;
					qa_q <= prod[XW +: 8];
					h_q  <= h_q << 8;
				end else begin
					rem_q <= rem_next;
					if (mcnt_q == 4'd0) begin
						home_q <= rem_next;
					end
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign home = home_q;
endmodule

### sim/tb_lpht_chan_if.sv
// Testbench-side types for request and response transactions.
// Depends on lpht_pkg only.
package tb_lpht_types;
	import lpht_pkg::*;

	typedef struct {
		lpht_op_t    op;
		logic [63:0] key;
		logic [3:0]  len;
		logic [63:0] value;
	} lookup_req_t;

	typedef struct {
		logic        ok;
		logic [63:0] read_value;
		logic [6:0]  live_entries;
	} lookup_rsp_t;
endpackage

### sim/tb_linear_probe_hash_table.sv
// Testbench for linear_probe_hash_table: drives set/get/delete requests, keeps a
// software copy of the table to predict every response, and checks them in order.
// Depends on lpht_pkg, lpht_if, tb_lpht_types and the RTL.
module tb_linear_probe_hash_table;
	timeunit 1ns;
	timeprecision 1ps;
	import lpht_pkg::*;
	import tb_lpht_types::*;

	localparam int DEPTH       = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [63:0] PRIME = 64'd1099511628211;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	lpht_req_if req ();
	lpht_rsp_if rsp ();

	linear_probe_hash_table #(.TABLE_DEPTH(DEPTH), .KEY_BYTES(8)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// shadow copy of the table
	lpht_mark_t  shadow_mark [DEPTH];
	logic [63:0] shadow_key  [DEPTH];
	logic [3:0]  shadow_len  [DEPTH];
	logic [63:0] shadow_val  [DEPTH];
	int          shadow_live;

	lookup_rsp_t pending_rsp[$];
	int  error_count = 0;
	int  cycle_count = 0;
	bit  sender_gaps = 1'b1;  // random idle bursts on the request side
	bit  sink_gaps = 1'b1;    // random stall bursts on the response side
	int  sink_hold = 0;       // forced long stall, counted down in cycles
	int  hold_asks = 0;       // bumped by a test to start a long stall
	int  hold_seen = 0;
	logic [63:0] key_pool [16];
	logic [3:0]  len_pool [16];

	function automatic logic [63:0] fnv1a(logic [63:0] key, int len);
		logic [63:0] h;
		h = 64'hcbf29ce484222325;
		for (int i = 0; i < len; i++) begin
			h = (h ^ {56'd0, key[i*8 +: 8]}) * PRIME;
		end
		return h;
	endfunction

	// applies one request to the shadow table and returns the expected response
	function automatic lookup_rsp_t table_apply(lookup_req_t r);
		lookup_rsp_t res;
		int len, home, s;
		logic [63:0] key;
		len = (r.len > 8) ? 8 : int'(r.len);
		key = (len >= 8) ? r.key : (r.key & ((64'd1 << (8 * len)) - 64'd1));
		home = int'(fnv1a(key, len) % DEPTH);
		res.ok = 1'b0;
		res.read_value = '0;
		if (r.op == OP_SET) begin
			// load limit: refused even when the key is already present
			if (shadow_live * 10 < DEPTH * 7) begin
				for (int i = 0; i < DEPTH; i++) begin
					s = (home + i) % DEPTH;
					if (shadow_mark[s] != MARK_LIVE) begin
						shadow_mark[s] = MARK_LIVE;
						shadow_key[s] = key;
						shadow_len[s] = 4'(len);
						shadow_val[s] = r.value;
						shadow_live++;
						res.ok = 1'b1;
						break;
					end
					if (shadow_len[s] == 4'(len) && shadow_key[s] == key) begin
						shadow_val[s] = r.value;
						res.ok = 1'b1;
						break;
					end
				end
			end
		end else if (r.op == OP_GET || r.op == OP_DEL) begin
			for (int i = 0; i < DEPTH; i++) begin
				s = (home + i) % DEPTH;
				if (shadow_mark[s] == MARK_EMPTY) break;
				if (shadow_mark[s] == MARK_TOMB) continue;
				if (shadow_len[s] == 4'(len) && shadow_key[s] == key) begin
					res.ok = 1'b1;
					if (r.op == OP_GET) begin
						res.read_value = shadow_val[s];
					end else begin
						shadow_mark[s] = MARK_TOMB;
						shadow_val[s] = '0;
						if (shadow_live > 0) shadow_live--;
					end
					break;
				end
			end
		end
		res.live_entries = 7'(shadow_live);
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
		error_count++;
	endtask

	// valid stays high after an accept; wait_drained lowers it, as does the next call when it idles first
	task automatic send_request(lpht_op_t op, logic [63:0] key, logic [3:0] len,
			logic [63:0] value);
		lookup_req_t r;
		int gap;
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		r.op = op;
		r.key = key;
		r.len = len;
		r.value = value;
		req.valid <= 1'b1;
		req.operation <= op;
		req.key_bytes <= key;
		req.key_length <= len;
		req.new_value <= value;
		do @(posedge clk); while (!req.ready);
		pending_rsp.push_back(table_apply(r));
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// key with nonzero bytes; occasionally one byte set to zero
	function automatic logic [63:0] random_key();
		logic [63:0] k;
		k = {$urandom, $urandom};
		for (int b = 0; b < 8; b++) begin
			if (k[b*8 +: 8] == 8'd0) k[b*8 +: 8] = 8'h41;
		end
		if ($urandom_range(0, 7) == 0) k[$urandom_range(0, 7)*8 +: 8] = 8'd0;
		return k;
	endfunction

	function automatic lpht_op_t random_op();
		int x;
		x = $urandom_range(0, 9);
		return (x < 4) ? OP_SET : (x < 7) ? OP_GET : OP_DEL;
	endfunction

	// response side: random stalls, a forced long hold, checks in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (pending_rsp.size() == 0) begin
					report_mismatch("unexpected response", 64'd0, 64'd0);
				end else begin
					if (rsp.ok !== pending_rsp[0].ok)
						report_mismatch("ok", rsp.ok, pending_rsp[0].ok);
					if (rsp.read_value !== pending_rsp[0].read_value)
						report_mismatch("read_value", rsp.read_value,
							pending_rsp[0].read_value);
					if (rsp.live_entries !== pending_rsp[0].live_entries)
						report_mismatch("live_entries", rsp.live_entries,
							pending_rsp[0].live_entries);
					void'(pending_rsp.pop_front());
				end
			end
			if (hold_asks != hold_seen) begin
				hold_seen <= hold_asks;
				sink_hold <= 300;
				rsp.ready <= 1'b0;
			end else if (sink_hold > 0) begin
				sink_hold <= sink_hold - 1;
				rsp.ready <= 1'b0;
			end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
				sink_hold <= $urandom_range(0, 10);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("tb_linear_probe_hash_table failed");
			$finish;
		end
	end

	// extremes of the fields and each corner case named for the table
	task automatic test_directed();
		send_request(OP_GET, 64'h0, 4'd0, 64'h0);                 // miss on empty table
		send_request(OP_SET, 64'hdead, 4'd0, 64'hffffffffffffffff); // empty key
		send_request(OP_GET, 64'h1234, 4'd0, 64'h0);              // same empty key
		send_request(OP_SET, 64'hffffffffffffffff, 4'd15, 64'h1);  // long length
		send_request(OP_GET, 64'hffffffffffffffff, 4'd8, 64'h0);
		send_request(OP_SET, 64'h00000000_00000061, 4'd1, 64'h5);
		send_request(OP_SET, 64'hff00000000000061, 4'd1, 64'h6);   // bytes above ignored
		send_request(OP_GET, 64'h61, 4'd1, 64'h0);
		send_request(OP_GET, 64'h61, 4'd2, 64'h0);                 // zero byte in length
		send_request(OP_SET, 64'h0061, 4'd2, 64'h7);
		send_request(OP_GET, 64'h61, 4'd2, 64'h0);
		send_request(OP_DEL, 64'h61, 4'd1, 64'h0);
		send_request(OP_GET, 64'h61, 4'd1, 64'h0);
		send_request(OP_DEL, 64'h61, 4'd1, 64'h0);                 // delete twice
		send_request(OP_SET, 64'h61, 4'd1, 64'h8);                 // reuse tombstone
		send_request(OP_GET, 64'h61, 4'd1, 64'h0);
		send_request(lpht_op_t'(2'd3), 64'h61, 4'd1, 64'h9);       // unknown op
		send_request(OP_GET, 64'h61, 4'd1, 64'h0);
		send_request(OP_DEL, 64'h8000000000000000, 4'd8, 64'h0);
	endtask

	// fill to the load limit, probe refusals, then drain with deletes
	task automatic test_load_limit();
		for (int i = 0; i < 50; i++)
			send_request(OP_SET, 64'h0101010101010000 | i, 4'd8, {$urandom, $urandom});
		send_request(OP_SET, 64'h0101010101010000, 4'd8, 64'h2);  // present, still refused
		for (int i = 0; i < 50; i++)
			send_request((i % 3 == 0) ? OP_GET : OP_DEL, 64'h0101010101010000 | i,
				4'd8, 64'h0);
		for (int i = 0; i < 50; i++)
			send_request(OP_DEL, 64'h0101010101010000 | i, 4'd8, 64'h0);
	endtask

	// hold the response side off while requests keep coming
	task automatic test_backpressure();
		hold_asks++;
		for (int i = 0; i < 10; i++)
			send_request(random_op(), {56'd0, 8'(key_pool[i][7:0])}, 4'd1, 64'(i));
		wait_drained();   // sender pauses until every response has come back
	endtask

	task automatic test_random(int count);
		int k;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 4) != 0) begin
				k = $urandom_range(0, 15);
				send_request(random_op(), key_pool[k], len_pool[k], {$urandom, $urandom});
			end else begin
				send_request(random_op(), random_key(), 4'($urandom_range(0, 15)),
					{$urandom, $urandom});
			end
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.operation = OP_GET;
		req.key_bytes = '0;
		req.key_length = '0;
		req.new_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			shadow_mark[i] = MARK_EMPTY;
			shadow_key[i] = '0;
			shadow_len[i] = '0;
			shadow_val[i] = '0;
		end
		shadow_live = 0;
		for (int i = 0; i < 16; i++) begin
			key_pool[i] = random_key();
			len_pool[i] = 4'($urandom_range(0, 8));
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_load_limit();
		test_backpressure();
		test_random(170);
		// last stretch with no idling on either side
		sender_gaps = 1'b0;
		sink_gaps = 1'b0;
		test_random(100);
		wait_drained();
		repeat (200) @(posedge clk);
		if (error_count == 0 && pending_rsp.size() == 0) begin
			$display("tb_linear_probe_hash_table passed");
		end else begin
			$display("tb_linear_probe_hash_table failed");
		end
		$finish;
	end
endmodule
